// ===== rtl/rpht_pkg.sv =====
// shared constants, codes and hash mix functions for the rehash probe hash table
`timescale 1ns / 1ps

package rpht_pkg;

  // default sizes
  localparam int SLOTS_DEF  = 1024;
  localparam int PROBES_DEF = 5;

  // action codes
  localparam logic [1:0] ACT_INSERT = 2'd0;
  localparam logic [1:0] ACT_DELETE = 2'd1;
  localparam logic [1:0] ACT_LOOKUP = 2'd2;

  // status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_MISSING = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;

  // mix constants
  localparam logic [31:0] MIX_C1 = 32'h7ed55d16;
  localparam logic [31:0] MIX_C2 = 32'hc761c23c;
  localparam logic [31:0] MIX_C3 = 32'h165667b1;
  localparam logic [31:0] MIX_C4 = 32'hd3a2646c;
  localparam logic [31:0] MIX_C5 = 32'hfd7046c5;
  localparam logic [31:0] MIX_C6 = 32'hb55a4f09;

  // first three steps of the integer mix
  function automatic logic [31:0] mix_a(input logic [31:0] a);
    logic [31:0] t1;
    logic [31:0] t2;
    logic [31:0] t3;
    t1 = (a + MIX_C1) + (a << 12);
    t2 = (t1 ^ MIX_C2) ^ (t1 >> 19);
    t3 = (t2 + MIX_C3) + (t2 << 5);
    return t3;
  endfunction

  // last three steps of the integer mix
  function automatic logic [31:0] mix_b(input logic [31:0] a);
    logic [31:0] t4;
    logic [31:0] t5;
    logic [31:0] t6;
    t4 = (a + MIX_C4) ^ (a << 9);
    t5 = (t4 + MIX_C5) + (t4 << 3);
    t6 = (t5 ^ MIX_C6) ^ (t5 >> 16);
    return t6;
  endfunction

endpackage

// ===== rtl/rehash_probe_hash_table.sv =====
// top level of the rehash probe hash table: probe pipeline, table memory and control
`timescale 1ns / 1ps

// Hash table of SLOTS key/value entries held in one single-port-write memory with a
// registered read. An item is taken when start is high and busy is low; exactly one
// result follows on status, value_out and slot, marked by done for a single cycle, and
// the receiver must take it then. Probe hashes come from a mix unit split into mix_a
// and mix_b, run one after the other, and a new probe enters the slot pipeline only once
// both have run; each goes through a reciprocal modulo (three stages) and one memory
// read. A new item may be taken in the cycle that shows the result, not before. After
// reset the block clears the whole table with busy high.
module rehash_probe_hash_table #(
  parameter int SLOTS  = rpht_pkg::SLOTS_DEF,
  parameter int PROBES = rpht_pkg::PROBES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  action,
  input  logic [31:0] key,
  input  logic [31:0] value_in,
  output logic        done,
  output logic [1:0]  status,
  output logic [31:0] value_out,
  output logic [9:0]  slot
);

  import rpht_pkg::*;

  localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int RW = SW + 2;
  localparam int CW = $clog2(PROBES + 1);
  localparam int EW = 65;
  localparam logic [63:0] RECIP   = (64'd1 << 32) / 64'(SLOTS);
  localparam logic [31:0] RECIP_W = RECIP[31:0];
  localparam logic [31:0] SLOTS_W = 32'(SLOTS);
  localparam logic [RW-1:0] S1    = RW'(SLOTS);
  localparam logic [RW-1:0] S2    = RW'(2 * SLOTS);

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_RUN
  } state_t;

  state_t state;

  // item registers
  logic [1:0]  act_q;
  logic [31:0] key_q;
  logic [31:0] val_q;

  // hash generator
  logic          gen_run;
  logic          gen_ph;
  logic [31:0]   gen_h;
  logic [31:0]   gen_mid;
  logic [CW-1:0] gen_cnt;

  // modulo and read pipeline
  logic          m1_v, m2_v, m3_v, m4_v;
  logic          m1_last, m2_last, m3_last, m4_last;
  logic [31:0]   m1_h, m1_q;
  logic [RW-1:0] m2_r;
  logic [SW-1:0] m3_s, m4_s;
  logic [63:0]   prod;
  logic [31:0]   qs;
  logic [31:0]   diff;
  logic [RW-1:0] r_fix;

  // table memory, entry is {valid, key, value}
  logic [EW-1:0] mem [SLOTS];
  logic [EW-1:0] rd_q;
  logic          we;
  logic [SW-1:0] waddr;
  logic [EW-1:0] wdata;
  logic [SW-1:0] clr_cnt;

  // check stage
  logic        e_valid;
  logic [31:0] e_key;
  logic [31:0] e_val;
  logic        hit;
  logic        finish;
  logic [31:0] slot_wide;

  assign busy = (state != S_IDLE);

  // reciprocal modulo arithmetic
  assign prod = 64'(gen_h) * 64'(RECIP_W);
  assign qs   = m1_q * SLOTS_W;
  assign diff = m1_h - qs;

  always_comb begin
    if (m2_r >= S2) begin
      r_fix = m2_r - S2;
    end else if (m2_r >= S1) begin
      r_fix = m2_r - S1;
    end else begin
      r_fix = m2_r;
    end
  end

  // probe check against the read entry
  assign e_valid = rd_q[64];
  assign e_key   = rd_q[63:32];
  assign e_val   = rd_q[31:0];

  always_comb begin
    unique case (act_q)
      ACT_INSERT: hit = !e_valid;
      default:    hit = e_valid && (e_key == key_q);
    endcase
  end

  assign finish    = (state == S_RUN) && m4_v && (hit || m4_last);
  assign slot_wide = 32'(m4_s);

  // memory write select
  always_comb begin
    we    = 1'b0;
    waddr = m4_s;
    wdata = {1'b1, key_q, val_q};
    if (state == S_CLEAR) begin
      we    = 1'b1;
      waddr = clr_cnt;
      wdata = '0;
    end else if ((state == S_RUN) && m4_v && hit) begin
      unique case (act_q)
        ACT_INSERT: begin
          we    = 1'b1;
          wdata = {1'b1, key_q, val_q};
        end
        ACT_DELETE: begin
          we    = 1'b1;
          wdata = {1'b0, e_key, e_val};
        end
        default: begin
          we = 1'b0;
        end
      endcase
    end
  end

  // table memory
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_q <= mem[m3_s];
  end

  // control state and registered results
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_CLEAR;
      clr_cnt <= '0;
      done    <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_CLEAR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (clr_cnt == SW'(SLOTS - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (start) begin
            state <= S_RUN;
            act_q <= action;
            key_q <= key;
            val_q <= value_in;
          end
        end
        S_RUN: begin
          if (finish) begin
            state <= S_IDLE;
            done  <= 1'b1;
            if (hit) begin
              status    <= ST_OK;
              value_out <= ((act_q != ACT_INSERT) && (act_q != ACT_DELETE)) ? e_val : 32'd0;
              slot      <= slot_wide[9:0];
            end else begin
              status    <= (act_q == ACT_INSERT) ? ST_FULL : ST_MISSING;
              value_out <= 32'd0;
              slot      <= 10'd0;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // hash generator and slot pipeline
  always_ff @(posedge clk) begin
    if (rst) begin
      gen_run <= 1'b0;
      gen_ph  <= 1'b0;
      m1_v    <= 1'b0;
      m2_v    <= 1'b0;
      m3_v    <= 1'b0;
      m4_v    <= 1'b0;
    end else begin
      m1_v <= 1'b0;
      if ((state == S_IDLE) && start) begin
        gen_run <= 1'b1;
        gen_ph  <= 1'b0;
        gen_cnt <= '0;
        gen_h   <= key;
      end else if (gen_run) begin
        if (!gen_ph) begin
          // issue current hash, start its successor
          m1_v    <= 1'b1;
          m1_h    <= gen_h;
          m1_q    <= prod[63:32];
          m1_last <= (gen_cnt == CW'(PROBES - 1));
          gen_mid <= mix_a(gen_h);
          gen_cnt <= gen_cnt + 1'b1;
          gen_ph  <= 1'b1;
          if (gen_cnt == CW'(PROBES - 1)) begin
            gen_run <= 1'b0;
          end
        end else begin
          gen_h  <= mix_b(gen_mid);
          gen_ph <= 1'b0;
        end
      end

      m2_v    <= m1_v;
      m2_last <= m1_last;
      m2_r    <= diff[RW-1:0];
      m3_v    <= m2_v;
      m3_last <= m2_last;
      m3_s    <= r_fix[SW-1:0];
      m4_v    <= m3_v;
      m4_last <= m3_last;
      m4_s    <= m3_s;

      // drop probes still in flight once the item is settled
      if (finish) begin
        gen_run <= 1'b0;
        m1_v    <= 1'b0;
        m2_v    <= 1'b0;
        m3_v    <= 1'b0;
        m4_v    <= 1'b0;
      end
    end
  end

endmodule

// ===== verif/rehash_probe_hash_table_checker.sv =====
// reply checker for the rehash probe hash table: predicts every reply and compares it
`timescale 1ns / 1ps

module rehash_probe_hash_table_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic        busy,
  input  logic [1:0]  action,
  input  logic [31:0] key,
  input  logic [31:0] value_in,
  input  logic        done,
  input  logic [1:0]  status,
  input  logic [31:0] value_out,
  input  logic [9:0]  slot,
  output int          fails,
  output int          pending,
  output int          replies,
  output int          ok_count,
  output int          missing_count,
  output int          full_count
);

  import rpht_pkg::*;

  localparam int SLOT_COUNT  = SLOTS_DEF;
  localparam int PROBE_COUNT = PROBES_DEF;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] value;
    logic [9:0]  slot;
  } reply_t;

  // replies owed by the block, oldest first
  reply_t expected_replies[$];

  // shadow copy of the table
  logic        shadow_used  [SLOT_COUNT];
  logic [31:0] shadow_key   [SLOT_COUNT];
  logic [31:0] shadow_value [SLOT_COUNT];

  int fail_tally;
  int reply_tally;
  int ok_tally;
  int missing_tally;
  int full_tally;

  // six-step integer mix giving the next probe hash
  function automatic logic [31:0] jenkins_mix(input logic [31:0] h);
    logic [31:0] m;
    m = h;
    m = (m + MIX_C1) + (m << 12);
    m = (m ^ MIX_C2) ^ (m >> 19);
    m = (m + MIX_C3) + (m << 5);
    m = (m + MIX_C4) ^ (m << 9);
    m = (m + MIX_C5) + (m << 3);
    m = (m ^ MIX_C6) ^ (m >> 16);
    return m;
  endfunction

  // walk the probe chain for one request, updating the shadow table
  function automatic reply_t predict_table_access(input logic [1:0] op, input logic [31:0] k,
                                                  input logic [31:0] v);
    reply_t      r;
    logic [31:0] h;
    int unsigned idx;
    int          p;
    logic        settled;
    r.status = (op == ACT_INSERT) ? ST_FULL : ST_MISSING;
    r.value  = '0;
    r.slot   = '0;
    h        = k;
    settled  = 1'b0;
    for (p = 0; p < PROBE_COUNT; p++) begin
      if (!settled) begin
        idx = h % SLOT_COUNT;
        if (op == ACT_INSERT) begin
          if (!shadow_used[idx]) begin
            shadow_used[idx]  = 1'b1;
            shadow_key[idx]   = k;
            shadow_value[idx] = v;
            r.status = ST_OK;
            r.slot   = idx[9:0];
            settled  = 1'b1;
          end
        end else if (shadow_used[idx] && shadow_key[idx] == k) begin
          // delete clears, anything else reads the value
          if (op == ACT_DELETE) shadow_used[idx] = 1'b0;
          else r.value = shadow_value[idx];
          r.status = ST_OK;
          r.slot   = idx[9:0];
          settled  = 1'b1;
        end
        h = jenkins_mix(h);
      end
    end
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("[%0t] reply mismatch on %s: got %0h, expected %0h", $time, what, got, want);
    fail_tally++;
  endtask

  always @(posedge clk) begin
    reply_t want;
    if (rst) begin
      foreach (shadow_used[i]) shadow_used[i] = 1'b0;
      expected_replies.delete();
      fail_tally    = 0;
      reply_tally   = 0;
      ok_tally      = 0;
      missing_tally = 0;
      full_tally    = 0;
    end else begin
      // check the reply beat first: it belongs to an earlier request
      if (done === 1'b1) begin
        reply_tally++;
        if (expected_replies.size() == 0) begin
          report_mismatch("unrequested reply status", 32'(status), 32'd0);
        end else begin
          want = expected_replies.pop_front();
          if (status !== want.status)
            report_mismatch("status", 32'(status), 32'(want.status));
          if (value_out !== want.value) report_mismatch("value_out", value_out, want.value);
          if (slot !== want.slot) report_mismatch("slot", 32'(slot), 32'(want.slot));
          case (want.status)
            ST_OK:      ok_tally++;
            ST_MISSING: missing_tally++;
            default:    full_tally++;
          endcase
        end
      end
      // request beat accepted at this edge
      if (start === 1'b1 && busy === 1'b0)
        expected_replies.push_back(predict_table_access(action, key, value_in));
    end
    fails         <= fail_tally;
    pending       <= expected_replies.size();
    replies       <= reply_tally;
    ok_count      <= ok_tally;
    missing_count <= missing_tally;
    full_count    <= full_tally;
  end

endmodule

// ===== verif/rehash_probe_hash_table_test.sv =====
// testbench top for the rehash probe hash table: clock, reset, request stimulus and verdict
`timescale 1ns / 1ps

module rehash_probe_hash_table_test;
  import rpht_pkg::*;

  localparam logic [1:0] ACT_SPARE = 2'd3;  // unused code, behaves as a lookup
  localparam int STALL_LIMIT  = 5000;
  localparam int DRAIN_CYCLES = 4 + 2 * PROBES_DEF + 8;
  localparam int PHASE_BEATS  = 388;
  localparam int POOL_SIZE    = 32;

  logic        clk      = 1'b0;
  logic        rst      = 1'b1;
  logic        start    = 1'b0;
  logic [1:0]  action   = ACT_INSERT;
  logic [31:0] key      = '0;
  logic [31:0] value_in = '0;
  logic        busy;
  logic        done;
  logic [1:0]  status;
  logic [31:0] value_out;
  logic [9:0]  slot;

  int fails;
  int pending;
  int replies;
  int ok_count;
  int missing_count;
  int full_count;

  int          idle_pct  = 0;
  int          beats_sent = 0;
  int          quiet_run = 0;
  logic [31:0] key_pool [POOL_SIZE];

  rehash_probe_hash_table dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .action    (action),
    .key       (key),
    .value_in  (value_in),
    .done      (done),
    .status    (status),
    .value_out (value_out),
    .slot      (slot)
  );

  rehash_probe_hash_table_checker checker_i (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .action        (action),
    .key           (key),
    .value_in      (value_in),
    .done          (done),
    .status        (status),
    .value_out     (value_out),
    .slot          (slot),
    .fails         (fails),
    .pending       (pending),
    .replies       (replies),
    .ok_count      (ok_count),
    .missing_count (missing_count),
    .full_count    (full_count)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // watchdog: too long without any beat on either side ends the run
  always @(posedge clk) begin
    if ((start && !busy) || done) quiet_run <= 0;
    else quiet_run <= quiet_run + 1;
    if (quiet_run >= STALL_LIMIT) begin
      $display("watchdog: %0d cycles without a beat", quiet_run);
      $display("Verification failed");
      $finish;
    end
  end

  // one request beat, with random idle cycles ahead of it
  task automatic send_request(input logic [1:0] op, input logic [31:0] k,
                              input logic [31:0] v);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start    <= 1'b1;
    action   <= op;
    key      <= k;
    value_in <= v;
    @(posedge clk);
    while (busy) @(posedge clk);
    beats_sent++;
  endtask

  // half the pool shares a few low bit patterns so probe chains collide
  task automatic refresh_key_pool();
    logic [9:0]  crowd_low [4];
    logic [31:0] r;
    foreach (crowd_low[j]) crowd_low[j] = 10'($urandom_range(1023));
    for (int i = 0; i < POOL_SIZE; i++) begin
      r = $urandom();
      key_pool[i] = (i < POOL_SIZE / 2) ? {r[31:10], crowd_low[i % 4]} : r;
    end
  endtask

  task automatic send_random_request();
    int          pick;
    logic [1:0]  op;
    logic [31:0] k;
    pick = $urandom_range(99);
    if (pick < 40) op = ACT_INSERT;
    else if (pick < 65) op = ACT_DELETE;
    else if (pick < 94) op = ACT_LOOKUP;
    else op = ACT_SPARE;
    if ($urandom_range(99) < 80) k = key_pool[$urandom_range(POOL_SIZE - 1)];
    else k = $urandom();
    send_request(op, k, $urandom());
  endtask

  initial begin
    int phase_idle [4];
    phase_idle = '{0, 81, 14, 0};

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // directed: empty table, collisions on the first probe, a full chain, holes
    send_request(ACT_LOOKUP, 32'h0000_0000, 32'hFFFF_FFFF);
    send_request(ACT_DELETE, 32'hFFFF_FFFF, 32'h0000_0000);
    send_request(ACT_INSERT, 32'h0000_0000, 32'h0000_0000);
    send_request(ACT_INSERT, 32'h0000_0400, 32'hFFFF_FFFF);
    send_request(ACT_LOOKUP, 32'h0000_0400, 32'h0000_0000);
    for (int i = 0; i < PROBES_DEF + 1; i++)
      send_request(ACT_INSERT, 32'hFFFF_FFFF, 32'hA5A5_5A5A ^ i);
    send_request(ACT_SPARE,  32'hFFFF_FFFF, 32'h0000_0000);
    send_request(ACT_DELETE, 32'hFFFF_FFFF, 32'h0000_0000);
    send_request(ACT_LOOKUP, 32'hFFFF_FFFF, 32'h0000_0000);
    send_request(ACT_INSERT, 32'hFFFF_FFFF, 32'h5A5A_A5A5);
    send_request(ACT_DELETE, 32'h0000_0400, 32'h0000_0000);
    send_request(ACT_DELETE, 32'h0000_0400, 32'h0000_0000);
    send_request(ACT_LOOKUP, 32'h0000_0000, 32'h0000_0000);
    send_request(ACT_INSERT, 32'h5555_5555, 32'hAAAA_AAAA);
    send_request(ACT_LOOKUP, 32'h5555_5555, 32'h0000_0000);
    send_request(ACT_SPARE,  32'h1234_5678, 32'h8765_4321);
    send_request(ACT_LOOKUP, 32'hAAAA_AAAA, 32'h0000_0000);

    // random phases with the sender idling set per phase
    foreach (phase_idle[ph]) begin
      idle_pct = phase_idle[ph];
      refresh_key_pool();
      repeat (PHASE_BEATS) send_random_request();
    end
    start <= 1'b0;

    // drain: the watchdog bounds this wait
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("%0d requests sent over four idling phases, %0d replies checked",
             beats_sent, replies);
    $display("replies: %0d done or found, %0d key missing, %0d table full",
             ok_count, missing_count, full_count);
    if (fails == 0 && pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("%0d mismatches, %0d replies outstanding", fails, pending);
      $display("Verification failed");
    end
    $finish;
  end

endmodule
